// ===== rtl/tsd_pkg.sv =====
// ---------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants for the two-stack deque.
// ---------------------------------------------------------------------------
package tsd_pkg;

    localparam int CMD_W          = 3;
    localparam int POS_W          = 9;
    localparam int COUNT_W        = 10;
    localparam int STATUS_W       = 2;
    localparam int DEF_SIDE_DEPTH = 256;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_READ_AT    = 3'd2,
        CMD_WRITE_AT   = 3'd3,
        CMD_READ_FRONT = 3'd4,
        CMD_READ_BACK  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // what the in-flight command expects back from the memories
    typedef struct packed {
        logic    rd_front;
        logic    rd_back;
        status_t status;
    } tsd_meta_t;

    // memory strobes, one pair per side
    typedef struct packed {
        logic front_we;
        logic front_re;
        logic back_we;
        logic back_re;
    } ram_ctl_t;

endpackage

// ===== rtl/tsd_cmd_if.sv =====
// ---------------------------------------------------------------------------
// tsd_cmd_if
// Command channel: valid/ready with command, position and value.
// ---------------------------------------------------------------------------
interface tsd_cmd_if #(
    parameter int DATA_WIDTH = tsd_pkg::DEF_DATA_WIDTH
) ();
    logic                       valid;
    logic                       ready;
    logic [tsd_pkg::CMD_W-1:0]  command;
    logic [tsd_pkg::POS_W-1:0]  position;
    logic [DATA_WIDTH-1:0]      value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

// ===== rtl/tsd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// tsd_rsp_if
// Result channel: valid/ready with data, count, is_empty and status.
// ---------------------------------------------------------------------------
interface tsd_rsp_if #(
    parameter int DATA_WIDTH = tsd_pkg::DEF_DATA_WIDTH
) ();
    logic                        valid;
    logic                        ready;
    logic [DATA_WIDTH-1:0]       data;
    logic [tsd_pkg::COUNT_W-1:0] count;
    logic                        is_empty;
    tsd_pkg::status_t            status;

    modport source (output valid, output data, output count, output is_empty,
                    output status, input ready);
    modport sink   (input valid, input data, input count, input is_empty,
                    input status, output ready);
endinterface

// ===== rtl/tsd_ram.sv =====
// ---------------------------------------------------------------------------
// tsd_ram
// Generic single-port RAM, synchronous write, registered read.
// ---------------------------------------------------------------------------
module tsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/tsd_ctrl.sv =====
// ---------------------------------------------------------------------------
// tsd_ctrl
// Command decode, side counters and memory address mapping; holds the
// stage that waits for the memory read.
// ---------------------------------------------------------------------------
module tsd_ctrl #(
    parameter int SIDE_DEPTH = tsd_pkg::DEF_SIDE_DEPTH,
    parameter int DATA_WIDTH = tsd_pkg::DEF_DATA_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tsd_cmd_if.sink                       cmd,
    input  logic                          adv,
    output logic                          s1_valid,
    output tsd_pkg::tsd_meta_t            s1_meta,
    output logic [tsd_pkg::COUNT_W-1:0]   s1_count,
    output logic                          s1_empty,
    output tsd_pkg::ram_ctl_t             ram_ctl,
    output logic [$clog2(SIDE_DEPTH)-1:0] front_addr,
    output logic [$clog2(SIDE_DEPTH)-1:0] back_addr,
    output logic [DATA_WIDTH-1:0]         wdata
);
    import tsd_pkg::*;

    localparam int AW = $clog2(SIDE_DEPTH);
    localparam int CW = $clog2(SIDE_DEPTH + 1);
    localparam int TW = CW + 1;
    localparam int IW = (TW > POS_W) ? TW : POS_W;
    localparam logic [CW-1:0] FULL_C = CW'(SIDE_DEPTH);

    logic [CW-1:0]      front_cnt_reg, front_cnt_next;
    logic [CW-1:0]      back_cnt_reg, back_cnt_next;
    logic               s1_valid_reg;
    tsd_meta_t          s1_meta_reg, meta;
    logic [COUNT_W-1:0] s1_count_reg;
    logic               s1_empty_reg;

    logic               accept;
    logic [IW-1:0]      fc_x, bc_x, pos_x, total_x, total_next;
    logic [IW-1:0]      front_idx_x, back_idx_x;
    logic               in_range, front_hit;

    assign cmd.ready = !s1_valid_reg || adv;
    assign accept    = cmd.valid && cmd.ready;
    assign wdata     = cmd.value;

    assign fc_x        = IW'(front_cnt_reg);
    assign bc_x        = IW'(back_cnt_reg);
    assign pos_x       = IW'(cmd.position);
    assign total_x     = fc_x + bc_x;
    assign in_range    = pos_x < total_x;
    assign front_hit   = pos_x < fc_x;
    // front stack is stored in push order, so logical order is reversed
    assign front_idx_x = fc_x - pos_x - IW'(1);
    assign back_idx_x  = pos_x - fc_x;

    always_comb
    begin
        ram_ctl        = '0;
        front_addr     = AW'(front_cnt_reg);
        back_addr      = AW'(back_cnt_reg);
        meta           = '{rd_front: 1'b0, rd_back: 1'b0, status: ST_OK};
        front_cnt_next = front_cnt_reg;
        back_cnt_next  = back_cnt_reg;
        if (accept)
        begin
            unique case (cmd_t'(cmd.command))
                CMD_PUSH_FRONT:
                begin
                    if (front_cnt_reg == FULL_C)
                    begin
                        meta.status = ST_FULL;
                    end
                    else
                    begin
                        ram_ctl.front_we = 1'b1;
                        front_cnt_next   = front_cnt_reg + CW'(1);
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (back_cnt_reg == FULL_C)
                    begin
                        meta.status = ST_FULL;
                    end
                    else
                    begin
                        ram_ctl.back_we = 1'b1;
                        back_cnt_next   = back_cnt_reg + CW'(1);
                    end
                end
                CMD_READ_AT, CMD_WRITE_AT:
                begin
                    if (!in_range)
                    begin
                        meta.status = ST_RANGE;
                    end
                    else if (front_hit)
                    begin
                        front_addr = AW'(front_idx_x);
                        if (cmd_t'(cmd.command) == CMD_READ_AT)
                        begin
                            ram_ctl.front_re = 1'b1;
                            meta.rd_front    = 1'b1;
                        end
                        else
                        begin
                            ram_ctl.front_we = 1'b1;
                        end
                    end
                    else
                    begin
                        back_addr = AW'(back_idx_x);
                        if (cmd_t'(cmd.command) == CMD_READ_AT)
                        begin
                            ram_ctl.back_re = 1'b1;
                            meta.rd_back    = 1'b1;
                        end
                        else
                        begin
                            ram_ctl.back_we = 1'b1;
                        end
                    end
                end
                CMD_READ_FRONT:
                begin
                    if (total_x == '0)
                    begin
                        meta.status = ST_EMPTY;
                    end
                    else if (front_cnt_reg == '0)
                    begin
                        // no front items: the front is the bottom of the back stack
                        back_addr       = '0;
                        ram_ctl.back_re = 1'b1;
                        meta.rd_back    = 1'b1;
                    end
                    else
                    begin
                        front_addr       = AW'(front_cnt_reg - CW'(1));
                        ram_ctl.front_re = 1'b1;
                        meta.rd_front    = 1'b1;
                    end
                end
                CMD_READ_BACK:
                begin
                    if (total_x == '0)
                    begin
                        meta.status = ST_EMPTY;
                    end
                    else if (back_cnt_reg == '0)
                    begin
                        front_addr       = '0;
                        ram_ctl.front_re = 1'b1;
                        meta.rd_front    = 1'b1;
                    end
                    else
                    begin
                        back_addr       = AW'(back_cnt_reg - CW'(1));
                        ram_ctl.back_re = 1'b1;
                        meta.rd_back    = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign total_next = IW'(front_cnt_next) + IW'(back_cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cnt_reg <= '0;
            back_cnt_reg  <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            front_cnt_reg <= front_cnt_next;
            back_cnt_reg  <= back_cnt_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg  <= meta;
            s1_count_reg <= COUNT_W'(total_next);
            s1_empty_reg <= (total_next == '0);
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_meta  = s1_meta_reg;
    assign s1_count = s1_count_reg;
    assign s1_empty = s1_empty_reg;
endmodule

// ===== rtl/two_stack_deque.sv =====
// ---------------------------------------------------------------------------
// two_stack_deque
// Deque built from two grow-only stacks, each in its own RAM.
//
//   channel | dir | payload                          | transfer when
//   --------+-----+----------------------------------+----------------------
//   cmd     | in  | command, position, value         | cmd.valid & cmd.ready
//   rsp     | out | data, count, is_empty, status    | rsp.valid & rsp.ready
//
// One command per cycle sustained while rsp is not stalled; a result passes
// the RAM read register of the read stage and then the output register.
// Reset clears both counters; RAM contents are not cleared.
// A stalled rsp holds the output register, then the read stage, and then
// drops cmd.ready.
// ---------------------------------------------------------------------------
module two_stack_deque #(
    parameter int SIDE_DEPTH = tsd_pkg::DEF_SIDE_DEPTH,
    parameter int DATA_WIDTH = tsd_pkg::DEF_DATA_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    tsd_cmd_if.sink   cmd,
    tsd_rsp_if.source rsp
);
    import tsd_pkg::*;

    localparam int AW = $clog2(SIDE_DEPTH);

    logic                  adv;
    logic                  s1_valid;
    tsd_meta_t             s1_meta;
    logic [COUNT_W-1:0]    s1_count;
    logic                  s1_empty;
    ram_ctl_t              ram_ctl;
    logic [AW-1:0]         front_addr, back_addr;
    logic [DATA_WIDTH-1:0] wdata, front_rdata, back_rdata;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  empty_reg;
    status_t               status_reg;

    assign adv = s1_valid && (!out_valid_reg || rsp.ready);

    tsd_ctrl #(
        .SIDE_DEPTH (SIDE_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .adv        (adv),
        .s1_valid   (s1_valid),
        .s1_meta    (s1_meta),
        .s1_count   (s1_count),
        .s1_empty   (s1_empty),
        .ram_ctl    (ram_ctl),
        .front_addr (front_addr),
        .back_addr  (back_addr),
        .wdata      (wdata)
    );

    tsd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SIDE_DEPTH)
    ) u_front_ram (
        .clk   (clk),
        .we    (ram_ctl.front_we),
        .re    (ram_ctl.front_re),
        .addr  (front_addr),
        .wdata (wdata),
        .rdata (front_rdata)
    );

    tsd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SIDE_DEPTH)
    ) u_back_ram (
        .clk   (clk),
        .we    (ram_ctl.back_we),
        .re    (ram_ctl.back_re),
        .addr  (back_addr),
        .wdata (wdata),
        .rdata (back_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // RAM read data holds while the read stage is stalled (no new reads issue)
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            priority if (s1_meta.rd_front)
            begin
                data_reg <= front_rdata;
            end
            else if (s1_meta.rd_back)
            begin
                data_reg <= back_rdata;
            end
            else
            begin
                data_reg <= '0;
            end
            count_reg  <= s1_count;
            empty_reg  <= s1_empty;
            status_reg <= s1_meta.status;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.data     = data_reg;
    assign rsp.count    = count_reg;
    assign rsp.is_empty = empty_reg;
    assign rsp.status   = status_reg;
endmodule
